@@ design/voig_pkg.sv @@
package voig_pkg;

  typedef enum logic [1:0] {
    MODE_MARK    = 2'd0,
    MODE_FREE    = 2'd1,
    MODE_QUERY   = 2'd2,
    MODE_INFLATE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2,
    REG_RADIUS = 2'd3
  } reg_index_t;

  localparam int unsigned SizeW = 11;

endpackage

@@ design/voig_bitmem.sv @@
module voig_bitmem #(
  parameter int unsigned AW = 20
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);

  logic mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ design/voxel_occupancy_grid_inflate_unit.sv @@
// Mark, free and out-of-range items: result registered in the cycle after start; query: via S_QUERY.
// Inflate: one sweep copying the map to the snapshot, then for each voxel in the active region
// a walk over the offsets of the (2R-1)^3 cube, each neighbor read through the single snapshot read port.
// Reset (rst, synchronous): a clearing pass writes every one of the 2^AW entries of the map
// (2^20 at default sizes), with busy high; config writes are taken throughout.
// done is a one-cycle strobe; the receiver cannot stall it.
module voxel_occupancy_grid_inflate_unit #(
  parameter int unsigned X_CELLS    = 128,
  parameter int unsigned Y_CELLS    = 128,
  parameter int unsigned Z_CELLS    = 64,
  parameter int unsigned MAX_RADIUS = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  voig_pkg::mode_t     mode,
  input  logic [6:0]          x_index,
  input  logic [6:0]          y_index,
  input  logic [5:0]          z_index,
  output logic                done,
  output logic                is_occupied,
  output logic                index_error,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  voig_pkg::reg_index_t cfg_index,
  input  logic [7:0]          cfg_data
);
  import voig_pkg::*;

  localparam int unsigned XW = (X_CELLS > 1) ? $clog2(X_CELLS) : 1;
  localparam int unsigned YW = (Y_CELLS > 1) ? $clog2(Y_CELLS) : 1;
  localparam int unsigned ZW = (Z_CELLS > 1) ? $clog2(Z_CELLS) : 1;
  localparam int unsigned AW = XW + YW + ZW;
  localparam int unsigned RW = $clog2(MAX_RADIUS + 1);
  localparam int unsigned OW = RW + 1;
  localparam int unsigned DW = 2 * RW + 2;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_QUERY, S_COPY, S_COPY_END, S_ISSUE, S_CHECK
  } state_t;

  state_t state;
  logic [7:0] size_x;
  logic [7:0] size_y;
  logic [6:0] size_z;
  logic [2:0] radius_cells;
  logic [AW-1:0] sweep;
  logic          cp_valid;
  logic [AW-1:0] cp_addr;
  logic [XW-1:0] cx;
  logic [YW-1:0] cy;
  logic [ZW-1:0] cz;
  logic signed [OW-1:0] ox, oy, oz;

  logic [SizeW-1:0] sx, sy, sz;
  logic [RW-1:0]    rr;
  logic signed [OW-1:0] rm1, neg_rm1;
  logic             req_err;
  logic [AW-1:0]    req_addr, cell_addr, nb_addr;
  logic signed [SizeW:0] nx, ny, nz;
  logic             nb_ok, in_sphere;
  logic [RW-1:0]    ax, ay, az;
  logic [DW-1:0]    dsq;
  logic             last_off, last_cell, hit, advance, cell_next, accept;

  logic          occ_we, occ_wdata, occ_rdata;
  logic [AW-1:0] occ_waddr, occ_raddr;
  logic          snap_rdata;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);
  assign accept    = start && (state == S_IDLE);

  assign sx = (SizeW'(size_x) > SizeW'(X_CELLS)) ? SizeW'(X_CELLS) : SizeW'(size_x);
  assign sy = (SizeW'(size_y) > SizeW'(Y_CELLS)) ? SizeW'(Y_CELLS) : SizeW'(size_y);
  assign sz = (SizeW'(size_z) > SizeW'(Z_CELLS)) ? SizeW'(Z_CELLS) : SizeW'(size_z);
  assign rr = (5'(radius_cells) > 5'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(radius_cells);
  assign rm1     = OW'({1'b0, rr}) - OW'(1);
  assign neg_rm1 = -rm1;

  assign req_err = (SizeW'(x_index) >= sx) || (SizeW'(y_index) >= sy) ||
                   (SizeW'(z_index) >= sz);
  assign req_addr  = {XW'(x_index), YW'(y_index), ZW'(z_index)};
  assign cell_addr = {cx, cy, cz};

  // neighbor of the current voxel at the current sphere offset
  assign nx = $signed({1'b0, SizeW'(cx)}) + (SizeW + 1)'(ox);
  assign ny = $signed({1'b0, SizeW'(cy)}) + (SizeW + 1)'(oy);
  assign nz = $signed({1'b0, SizeW'(cz)}) + (SizeW + 1)'(oz);
  assign nb_addr = {nx[XW-1:0], ny[YW-1:0], nz[ZW-1:0]};

  assign ax = ox[OW-1] ? RW'(-ox) : RW'(ox);
  assign ay = oy[OW-1] ? RW'(-oy) : RW'(oy);
  assign az = oz[OW-1] ? RW'(-oz) : RW'(oz);
  assign dsq = DW'(ax) * DW'(ax) + DW'(ay) * DW'(ay) + DW'(az) * DW'(az);
  assign in_sphere = dsq < DW'(rr) * DW'(rr);
  assign nb_ok = in_sphere &&
                 !nx[SizeW] && (nx[SizeW-1:0] < sx) &&
                 !ny[SizeW] && (ny[SizeW-1:0] < sy) &&
                 !nz[SizeW] && (nz[SizeW-1:0] < sz);

  assign last_off  = (ox == rm1) && (oy == rm1) && (oz == rm1);
  assign last_cell = (SizeW'(cx) == sx - SizeW'(1)) && (SizeW'(cy) == sy - SizeW'(1)) &&
                     (SizeW'(cz) == sz - SizeW'(1));
  assign hit       = (state == S_CHECK) && snap_rdata;
  assign advance   = ((state == S_ISSUE) && !nb_ok) || ((state == S_CHECK) && !snap_rdata);
  assign cell_next = hit || (advance && last_off);

  always_comb begin
    occ_we    = 1'b0;
    occ_waddr = req_addr;
    occ_wdata = (mode == MODE_MARK);
    if (state == S_CLEAR) begin
      occ_we    = 1'b1;
      occ_waddr = sweep;
      occ_wdata = 1'b0;
    end else if (hit) begin
      occ_we    = 1'b1;
      occ_waddr = cell_addr;
      occ_wdata = 1'b1;
    end else if (accept && !req_err && (mode == MODE_MARK || mode == MODE_FREE)) begin
      occ_we = 1'b1;
    end
  end

  assign occ_raddr = (state == S_COPY) ? sweep : req_addr;

  voig_bitmem #(.AW(AW)) u_occ (
    .clk   (clk),
    .we    (occ_we),
    .waddr (occ_waddr),
    .wdata (occ_wdata),
    .raddr (occ_raddr),
    .rdata (occ_rdata)
  );

  voig_bitmem #(.AW(AW)) u_snap (
    .clk   (clk),
    .we    (cp_valid),
    .waddr (cp_addr),
    .wdata (occ_rdata),
    .raddr (nb_addr),
    .rdata (snap_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x       <= 8'd128;
      size_y       <= 8'd128;
      size_z       <= 7'd64;
      radius_cells <= 3'd4;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SIZE_X: size_x       <= cfg_data;
        REG_SIZE_Y: size_y       <= cfg_data;
        REG_SIZE_Z: size_z       <= cfg_data[6:0];
        REG_RADIUS: radius_cells <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cp_addr <= sweep;
    if (rst) begin
      state       <= S_CLEAR;
      sweep       <= '0;
      cp_valid    <= 1'b0;
      done        <= 1'b0;
      is_occupied <= 1'b0;
      index_error <= 1'b0;
      cx <= '0;
      cy <= '0;
      cz <= '0;
      ox <= '0;
      oy <= '0;
      oz <= '0;
    end else begin
      done     <= 1'b0;
      cp_valid <= (state == S_COPY);
      unique case (state)
        S_CLEAR: begin
          sweep <= sweep + AW'(1);
          if (&sweep) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            if (mode == MODE_INFLATE) begin
              sweep <= '0;
              state <= S_COPY;
            end else if (req_err) begin
              done        <= 1'b1;
              is_occupied <= 1'b0;
              index_error <= 1'b1;
            end else if (mode == MODE_QUERY) begin
              state <= S_QUERY;
            end else begin
              done        <= 1'b1;
              is_occupied <= (mode == MODE_MARK);
              index_error <= 1'b0;
            end
          end
        end
        S_QUERY: begin
          done        <= 1'b1;
          is_occupied <= occ_rdata;
          index_error <= 1'b0;
          state       <= S_IDLE;
        end
        S_COPY: begin
          sweep <= sweep + AW'(1);
          if (&sweep) state <= S_COPY_END;
        end
        S_COPY_END: begin
          cx <= '0;
          cy <= '0;
          cz <= '0;
          ox <= neg_rm1;
          oy <= neg_rm1;
          oz <= neg_rm1;
          if (rr == '0 || sx == '0 || sy == '0 || sz == '0) begin
            done        <= 1'b1;
            is_occupied <= 1'b0;
            index_error <= 1'b0;
            state       <= S_IDLE;
          end else begin
            state <= S_ISSUE;
          end
        end
        S_ISSUE, S_CHECK: begin
          if (cell_next) begin
            ox    <= neg_rm1;
            oy    <= neg_rm1;
            oz    <= neg_rm1;
            state <= S_ISSUE;
            if (last_cell) begin
              done        <= 1'b1;
              is_occupied <= 1'b0;
              index_error <= 1'b0;
              state       <= S_IDLE;
            end else if (SizeW'(cz) == sz - SizeW'(1)) begin
              cz <= '0;
              if (SizeW'(cy) == sy - SizeW'(1)) begin
                cy <= '0;
                cx <= cx + XW'(1);
              end else begin
                cy <= cy + YW'(1);
              end
            end else begin
              cz <= cz + ZW'(1);
            end
          end else if (advance) begin
            state <= S_ISSUE;
            if (oz == rm1) begin
              oz <= neg_rm1;
              if (oy == rm1) begin
                oy <= neg_rm1;
                ox <= ox + OW'(1);
              end else begin
                oy <= oy + OW'(1);
              end
            end else begin
              oz <= oz + OW'(1);
            end
          end else begin
            state <= S_CHECK;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_err_not_occ: assert property (@(posedge clk) disable iff (rst)
    done && index_error |-> !is_occupied)
    else $error("index error reported with occupancy set");

  a_accept_resp: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy || done)
    else $error("accepted item neither in progress nor answered");

  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) || $past(start))
    else $error("result strobe without an item");

  a_hit_in_scan: assert property (@(posedge clk) disable iff (rst)
    occ_we && occ_wdata && !accept |-> state == S_CHECK)
    else $error("inflation mark outside the scan");

endmodule

@@ tb/sv/voxel_occupancy_grid_inflate_unit_tb.sv @@
module voxel_occupancy_grid_inflate_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import voig_pkg::*;

  localparam int unsigned XC = 128;
  localparam int unsigned YC = 128;
  localparam int unsigned ZC = 64;
  localparam int unsigned RMAX = 7;
  localparam longint unsigned CycleLimit = 150_000_000;

  typedef struct packed {
    logic occ;
    logic err;
  } voxel_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  mode_t mode = MODE_QUERY;
  logic [6:0] x_index = '0;
  logic [6:0] y_index = '0;
  logic [5:0] z_index = '0;
  logic done;
  logic is_occupied;
  logic index_error;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  reg_index_t cfg_index = REG_SIZE_X;
  logic [7:0] cfg_data = '0;

  // grid model and its registers
  bit grid_occ [0:XC*YC*ZC-1];
  int unsigned cur_sx, cur_sy, cur_sz, cur_rad;

  voxel_result_t pending_results[$];
  int unsigned mismatch_count = 0;
  int unsigned idle_pct = 0;
  longint unsigned cycle_count = 0;

  voxel_occupancy_grid_inflate_unit i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .x_index(x_index), .y_index(y_index), .z_index(z_index), .done(done),
    .is_occupied(is_occupied), .index_error(index_error), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  function automatic int unsigned cell_of(int unsigned x, int unsigned y, int unsigned z);
    return (x * YC + y) * ZC + z;
  endfunction

  function automatic int unsigned clipped(int unsigned v, int unsigned top);
    return (v < top) ? v : top;
  endfunction

  // dilate the in-range occupied set by the sphere d^2 < r^2
  function automatic void grow_occupied();
    int unsigned sx, sy, sz, r;
    int unsigned seeds[$];
    int sxi, syi, szi, tx, ty, tz, rr;
    sx = clipped(cur_sx, XC);
    sy = clipped(cur_sy, YC);
    sz = clipped(cur_sz, ZC);
    r = clipped(cur_rad, RMAX);
    if (r == 0 || sx == 0 || sy == 0 || sz == 0) return;
    rr = r;
    for (int unsigned x = 0; x < sx; x++)
      for (int unsigned y = 0; y < sy; y++)
        for (int unsigned z = 0; z < sz; z++)
          if (grid_occ[cell_of(x, y, z)]) seeds = {seeds, cell_of(x, y, z)};
    foreach (seeds[i]) begin
      sxi = seeds[i] / (YC * ZC);
      syi = (seeds[i] / ZC) % YC;
      szi = seeds[i] % ZC;
      for (int dx = -(rr - 1); dx <= rr - 1; dx++)
        for (int dy = -(rr - 1); dy <= rr - 1; dy++)
          for (int dz = -(rr - 1); dz <= rr - 1; dz++) begin
            if (dx * dx + dy * dy + dz * dz >= rr * rr) continue;
            tx = sxi + dx;
            ty = syi + dy;
            tz = szi + dz;
            if (tx < 0 || ty < 0 || tz < 0) continue;
            if (tx >= int'(sx) || ty >= int'(sy) || tz >= int'(sz)) continue;
            grid_occ[cell_of(tx, ty, tz)] = 1'b1;
          end
    end
  endfunction

  function automatic voxel_result_t predict_voxel(mode_t m, int unsigned x, int unsigned y,
                                                  int unsigned z);
    voxel_result_t res;
    int unsigned c;
    res = '0;
    if (m == MODE_INFLATE) begin
      grow_occupied();
      return res;
    end
    if (x >= clipped(cur_sx, XC) || y >= clipped(cur_sy, YC) || z >= clipped(cur_sz, ZC)) begin
      res.err = 1'b1;
      return res;
    end
    c = cell_of(x, y, z);
    if (m == MODE_MARK) grid_occ[c] = 1'b1;
    else if (m == MODE_FREE) grid_occ[c] = 1'b0;
    res.occ = grid_occ[c];
    return res;
  endfunction

  always @(posedge clk) begin
    voxel_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result occ=%0b err=%0b", is_occupied, index_error);
      end else begin
        want = pending_results.pop_front();
        if (want.occ !== is_occupied || want.err !== index_error) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected occ=%0b err=%0b, got occ=%0b err=%0b",
                     want.occ, want.err, is_occupied, index_error);
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_results.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic send_voxel(mode_t m, int unsigned x, int unsigned y, int unsigned z);
    start <= 1'b1;
    mode <= m;
    x_index <= x[6:0];
    y_index <= y[6:0];
    z_index <= z[5:0];
    do @(posedge clk); while (busy);
    pending_results = {pending_results, predict_voxel(m, x[6:0], y[6:0], z[5:0])};
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic write_reg(reg_index_t idx, int unsigned val);
    start <= 1'b0;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[7:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SIZE_X: cur_sx = val & 8'hFF;
      REG_SIZE_Y: cur_sy = val & 8'hFF;
      REG_SIZE_Z: cur_sz = val & 8'h7F;
      REG_RADIUS: cur_rad = val & 8'h07;
      default: ;
    endcase
  endtask

  task automatic set_grid(int unsigned sx, int unsigned sy, int unsigned sz, int unsigned r);
    write_reg(REG_SIZE_X, sx);
    write_reg(REG_SIZE_Y, sy);
    write_reg(REG_SIZE_Z, sz);
    write_reg(REG_RADIUS, r);
  endtask

  task automatic test_corners();
    send_voxel(MODE_MARK, 0, 0, 0);
    send_voxel(MODE_MARK, 127, 127, 63);
    send_voxel(MODE_QUERY, 127, 127, 63);
    send_voxel(MODE_QUERY, 0, 0, 0);
    send_voxel(MODE_FREE, 0, 0, 0);
    send_voxel(MODE_QUERY, 0, 0, 0);
    send_voxel(MODE_QUERY, 85, 42, 21);
    send_voxel(MODE_FREE, 127, 127, 63);
  endtask

  task automatic test_index_range();
    set_grid(5, 6, 7, 4);
    send_voxel(MODE_MARK, 5, 0, 0);
    send_voxel(MODE_MARK, 0, 6, 0);
    send_voxel(MODE_QUERY, 0, 0, 7);
    send_voxel(MODE_MARK, 4, 5, 6);
    send_voxel(MODE_QUERY, 4, 5, 6);
    // size zero: every access is out of range
    write_reg(REG_SIZE_Y, 0);
    send_voxel(MODE_QUERY, 0, 0, 0);
    send_voxel(MODE_INFLATE, 0, 0, 0);
    // oversized registers saturate
    set_grid(255, 200, 127, 4);
    send_voxel(MODE_MARK, 127, 127, 63);
    send_voxel(MODE_QUERY, 127, 127, 63);
  endtask

  task automatic test_inflate_directed();
    // radius zero on the full grid leaves the map alone
    set_grid(128, 128, 64, 0);
    send_voxel(MODE_INFLATE, 0, 0, 0);
    send_voxel(MODE_QUERY, 126, 127, 63);
    // small grid, largest radius, old contents beyond the sizes survive
    set_grid(8, 8, 8, 7);
    send_voxel(MODE_MARK, 3, 3, 3);
    send_voxel(MODE_INFLATE, 0, 0, 0);
    send_voxel(MODE_QUERY, 7, 7, 7);
    send_voxel(MODE_QUERY, 0, 0, 7);
    set_grid(6, 5, 4, 1);
    send_voxel(MODE_MARK, 0, 4, 0);
    send_voxel(MODE_INFLATE, 0, 0, 0);
    send_voxel(MODE_QUERY, 1, 4, 0);
  endtask

  task automatic test_random_traffic(int unsigned items);
    int unsigned sx, sy, sz, pick, inflate_at;
    sx = ($urandom_range(9) == 0) ? 128 : $urandom_range(1, 10);
    sy = ($urandom_range(9) == 0) ? 128 : $urandom_range(1, 10);
    sz = ($urandom_range(9) == 0) ? 64 : $urandom_range(1, 10);
    set_grid(sx, sy, sz, $urandom_range(0, 7));
    // inflate only when the active region is small
    inflate_at = (sx * sy * sz <= 1000) ? $urandom_range(items / 4, items - 10) : items;
    for (int unsigned n = 0; n < items; n++) begin
      pick = $urandom_range(99);
      if (n == inflate_at)
        send_voxel(MODE_INFLATE, $urandom_range(127), $urandom_range(127), $urandom_range(63));
      else if (pick < 90)
        send_voxel(mode_t'($urandom_range(2)), $urandom_range(clipped(sx, XC) - 1),
                   $urandom_range(clipped(sy, YC) - 1), $urandom_range(clipped(sz, ZC) - 1));
      else
        send_voxel(mode_t'($urandom_range(2)), $urandom_range(127), $urandom_range(127),
                   $urandom_range(63));
    end
  endtask

  task automatic test_pause_drain();
    send_voxel(MODE_MARK, 1, 1, 1);
    start <= 1'b0;
    wait_drained();
    send_voxel(MODE_QUERY, 1, 1, 1);
  endtask

  initial begin
    int unsigned idle_plan[4];
    idle_plan = '{0, 62, 0, 19};
    cur_sx = 128;
    cur_sy = 128;
    cur_sz = 64;
    cur_rad = 4;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    wait_drained();
    test_corners();
    test_index_range();
    test_inflate_directed();
    for (int p = 0; p < 4; p++) begin
      idle_pct = idle_plan[p];
      test_random_traffic(150);
      if (p == 1) test_pause_drain();
    end
    start <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/voig_pkg.sv
design/voig_bitmem.sv
design/voxel_occupancy_grid_inflate_unit.sv
tb/sv/voxel_occupancy_grid_inflate_unit_tb.sv
